FILE: rtl/core/rfd_pkg.sv
// ----------------------------------------------------------------------------
// Report frame deframer package
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int POS_W          = 17;
    localparam int LEN_W          = 16;
    localparam int HEADER_BYTES   = 4;
    localparam int FIELDS_START   = 6;
    localparam int ENERGY_START   = 9;
    localparam int FRAME_OVERHEAD = 10;
    localparam int FOOTER_BYTES   = 4;

    localparam logic [31:0] HEADER_RESET = 32'd4059165169;
    localparam logic [31:0] FOOTER_RESET = 32'd4126537205;
    localparam logic [7:0]  STATUS_RESET = 8'd2;
    localparam logic [7:0]  NOTGT_RESET  = 8'd0;

    typedef enum logic [1:0] {
        REG_HEADER_WORD   = 2'd0,
        REG_FOOTER_WORD   = 2'd1,
        REG_HIGHEST_VALID = 2'd2,
        REG_NO_TARGET     = 2'd3
    } rfd_reg_idx_t;

    typedef struct packed {
        logic take;       // latch the accepted input byte
        logic clear;      // return per-buffer state to reset values
        logic rd_en;      // read energy RAMs at the current gate
        logic gate_clr;
        logic gate_inc;
        logic show_err;   // present the error result
    } rfd_cmd_t;

    typedef struct packed {
        logic frame_ok;
        logic gate_last;
    } rfd_stat_t;

endpackage

FILE: rtl/core/rfd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/rfd_datapath.sv
// ----------------------------------------------------------------------------
// Report frame deframer datapath
// Byte parsing, header/footer checks, field capture, energy RAMs, result mux.
// ----------------------------------------------------------------------------
module rfd_datapath import rfd_pkg::*; #(
    parameter int GATES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  rfd_reg_idx_t cfg_idx,
    input  logic [31:0]  cfg_data,
    input  logic [7:0]   rx_byte,
    input  rfd_cmd_t     cmd,
    output rfd_stat_t    stat,
    output logic         frame_error,
    output logic [7:0]   detect_status,
    output logic [15:0]  target_distance,
    output logic [3:0]   gate_number,
    output logic [31:0]  moving_energy,
    output logic [31:0]  stationary_energy,
    output logic         last_result
);

    localparam int GW         = (GATES > 1) ? $clog2(GATES) : 1;
    localparam int IW         = $clog2(2 * GATES);
    localparam int ENERGY_END = ENERGY_START + 8 * GATES;
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(3 + 8 * GATES);

    logic [31:0]      hdr_word_reg;
    logic [31:0]      ftr_word_reg;
    logic [7:0]       hi_status_reg;
    logic [7:0]       no_tgt_reg;

    logic [POS_W-1:0] pos_reg,    pos_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic             ftr_ok_reg, ftr_ok_next;
    logic [LEN_W-1:0] len_reg,    len_next;
    logic [7:0]       status_reg, status_next;
    logic [15:0]      dist_reg,   dist_next;
    logic [23:0]      word_reg,   word_next;
    logic [GW-1:0]    gate_reg,   gate_next;

    logic [POS_W:0]   ftr_base;
    logic [POS_W:0]   ftr_off;
    logic             in_footer;
    logic             in_energy;
    logic [POS_W-1:0] e_off;
    logic [IW-1:0]    e_idx;
    logic             e_static;
    logic             word_done;
    logic             m_we;
    logic             s_we;
    logic [GW-1:0]    m_addr;
    logic [GW-1:0]    s_addr;
    logic [31:0]      full_word;
    logic [31:0]      m_rd;
    logic [31:0]      s_rd;
    logic [7:0]       mapped_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_word_reg  <= HEADER_RESET;
            ftr_word_reg  <= FOOTER_RESET;
            hi_status_reg <= STATUS_RESET;
            no_tgt_reg    <= NOTGT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_HEADER_WORD:   hdr_word_reg  <= cfg_data;
                REG_FOOTER_WORD:   ftr_word_reg  <= cfg_data;
                REG_HIGHEST_VALID: hi_status_reg <= cfg_data[7:0];
                REG_NO_TARGET:     no_tgt_reg    <= cfg_data[7:0];
            endcase
        end
    end

    assign ftr_base  = (POS_W+1)'(len_reg) + (POS_W+1)'(FIELDS_START);
    assign ftr_off   = (POS_W+1)'(pos_reg) - ftr_base;
    assign in_footer = ((POS_W+1)'(pos_reg) >= ftr_base) &&
                       (ftr_off < (POS_W+1)'(FOOTER_BYTES));

    assign in_energy = (pos_reg >= POS_W'(ENERGY_START)) && (pos_reg < POS_W'(ENERGY_END));
    assign e_off     = pos_reg - POS_W'(ENERGY_START);
    assign e_idx     = e_off[IW+1:2];
    assign e_static  = (e_idx >= IW'(GATES));
    assign word_done = (e_off[1:0] == 2'd3);
    assign full_word = {rx_byte, word_reg};
    assign m_we      = cmd.take && in_energy && word_done && !e_static;
    assign s_we      = cmd.take && in_energy && word_done && e_static;
    assign m_addr    = GW'(e_idx);
    assign s_addr    = GW'(e_idx - IW'(GATES));

    always_comb
    begin
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        ftr_ok_next = ftr_ok_reg;
        len_next    = len_reg;
        status_next = status_reg;
        dist_next   = dist_reg;
        word_next   = word_reg;
        if (cmd.clear)
        begin
            pos_next    = '0;
            hdr_ok_next = 1'b1;
            ftr_ok_next = 1'b1;
            len_next    = '0;
            status_next = '0;
            dist_next   = '0;
            word_next   = '0;
        end
        else if (cmd.take)
        begin
            priority if (pos_reg < POS_W'(HEADER_BYTES))
            begin
                if (rx_byte != hdr_word_reg[8*pos_reg[1:0] +: 8])
                begin
                    hdr_ok_next = 1'b0;
                end
            end
            else if (pos_reg == POS_W'(4))
            begin
                len_next[7:0] = rx_byte;
            end
            else if (pos_reg == POS_W'(5))
            begin
                len_next[15:8] = rx_byte;
            end
            else if (pos_reg == POS_W'(6))
            begin
                status_next = rx_byte;
            end
            else if (pos_reg == POS_W'(7))
            begin
                dist_next[7:0] = rx_byte;
            end
            else if (pos_reg == POS_W'(8))
            begin
                dist_next[15:8] = rx_byte;
            end
            else if (in_energy)
            begin
                if (word_done)
                begin
                    word_next = '0;
                end
                else
                begin
                    word_next = {rx_byte, word_reg[23:8]};
                end
            end
            // footer position follows the received length; never hits before offset 6
            if (in_footer && (rx_byte != ftr_word_reg[8*ftr_off[1:0] +: 8]))
            begin
                ftr_ok_next = 1'b0;
            end
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        gate_next = gate_reg;
        if (cmd.gate_clr)
        begin
            gate_next = '0;
        end
        else if (cmd.gate_inc)
        begin
            gate_next = gate_reg + GW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            ftr_ok_reg <= 1'b1;
            len_reg    <= '0;
            status_reg <= '0;
            dist_reg   <= '0;
            word_reg   <= '0;
            gate_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            ftr_ok_reg <= ftr_ok_next;
            len_reg    <= len_next;
            status_reg <= status_next;
            dist_reg   <= dist_next;
            word_reg   <= word_next;
            gate_reg   <= gate_next;
        end
    end

    rfd_ram #(
        .WIDTH (32),
        .DEPTH (GATES)
    ) u_motion_ram (
        .clk     (clk),
        .wr_en   (m_we),
        .wr_addr (m_addr),
        .wr_data (full_word),
        .rd_en   (cmd.rd_en),
        .rd_addr (gate_reg),
        .rd_data (m_rd)
    );

    rfd_ram #(
        .WIDTH (32),
        .DEPTH (GATES)
    ) u_static_ram (
        .clk     (clk),
        .wr_en   (s_we),
        .wr_addr (s_addr),
        .wr_data (full_word),
        .rd_en   (cmd.rd_en),
        .rd_addr (gate_reg),
        .rd_data (s_rd)
    );

    assign stat.frame_ok  = hdr_ok_reg && ftr_ok_reg && (len_reg >= MIN_LEN) &&
                            ((POS_W+1)'(pos_reg) >=
                             (POS_W+1)'(len_reg) + (POS_W+1)'(FRAME_OVERHEAD));
    assign stat.gate_last = (gate_reg == GW'(GATES - 1));

    assign mapped_status = (status_reg > hi_status_reg) ? no_tgt_reg : status_reg;

    assign frame_error       = cmd.show_err;
    assign detect_status     = cmd.show_err ? 8'd0  : mapped_status;
    assign target_distance   = cmd.show_err ? 16'd0 : dist_reg;
    assign gate_number       = cmd.show_err ? 4'd0  : 4'(gate_reg);
    assign moving_energy     = cmd.show_err ? 32'd0 : m_rd;
    assign stationary_energy = cmd.show_err ? 32'd0 : s_rd;
    assign last_result       = cmd.show_err || stat.gate_last;

endmodule

FILE: rtl/core/rfd_ctrl.sv
// ----------------------------------------------------------------------------
// Report frame deframer controller
// Sequences byte intake, end-of-buffer check and per-gate or error result output.
// ----------------------------------------------------------------------------
module rfd_ctrl import rfd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      end_of_buffer,
    input  logic      out_stall,
    input  rfd_stat_t stat,
    output rfd_cmd_t  cmd,
    output logic      in_stall,
    output logic      out_valid
);

    typedef enum logic [4:0] {
        ST_TAKE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SHOW  = 5'b01000,
        ST_ERR   = 5'b10000
    } rfd_state_t;

    rfd_state_t state_reg, state_next;
    logic       in_acc;
    logic       out_acc;

    assign in_stall  = (state_reg != ST_TAKE);
    assign out_valid = (state_reg == ST_SHOW) || (state_reg == ST_ERR);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_TAKE:
            begin
                cmd.take = in_acc;
                if (in_acc && end_of_buffer)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.gate_clr = 1'b1;
                state_next   = stat.frame_ok ? ST_READ : ST_ERR;
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_acc)
                begin
                    if (stat.gate_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_TAKE;
                    end
                    else
                    begin
                        cmd.gate_inc = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_ERR:
            begin
                cmd.show_err = 1'b1;
                if (out_acc)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_TAKE;
                end
            end
            default:
            begin
                state_next = ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TAKE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/report_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// Report frame deframer
// Parses one received buffer (header, length, status, distance, per-gate
// energies, footer) and emits an error word or one result word per gate.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | sink      | in_valid / in_stall  | rx_byte, end_of_buffer
//  out     | source    | out_valid / out_stall| frame_error .. last_result
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte word per cycle while a buffer is collected. After the marked byte:
// a check state, then for each gate result an energy RAM read state followed
// by a present state, or the error result state; results wait on out_stall.
// Reset restores configuration defaults and per-buffer state; energy RAMs are
// not cleared. Intake stalls from the marked byte until the last result leaves.
// ----------------------------------------------------------------------------
module report_frame_deframer_unit import rfd_pkg::*; #(
    parameter int GATES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_error,
    output logic [7:0]  detect_status,
    output logic [15:0] target_distance,
    output logic [3:0]  gate_number,
    output logic [31:0] moving_energy,
    output logic [31:0] stationary_energy,
    output logic        last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rfd_cmd_t  cmd;
    rfd_stat_t stat;

    assign cfg_ready = 1'b1;

    rfd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .end_of_buffer (end_of_buffer),
        .out_stall     (out_stall),
        .stat          (stat),
        .cmd           (cmd),
        .in_stall      (in_stall),
        .out_valid     (out_valid)
    );

    rfd_datapath #(
        .GATES (GATES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_idx           (rfd_reg_idx_t'(cfg_index)),
        .cfg_data          (cfg_data),
        .rx_byte           (rx_byte),
        .cmd               (cmd),
        .stat              (stat),
        .frame_error       (frame_error),
        .detect_status     (detect_status),
        .target_distance   (target_distance),
        .gate_number       (gate_number),
        .moving_energy     (moving_energy),
        .stationary_energy (stationary_energy),
        .last_result       (last_result)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("result word shown while intake open");

    a_eob_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && end_of_buffer) |=> in_stall)
        else $error("intake not held after end of buffer");

    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_result) |=> (!in_stall && !out_valid))
        else $error("intake not reopened after last result");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_error) |-> (last_result && gate_number == 4'd0))
        else $error("error result not a lone last word");
`endif

endmodule
